FILE: rtl/core/error_log_table_dedup_evict_defines.svh
// Assertion macros for the error log table.
`ifndef ERROR_LOG_TABLE_DEDUP_EVICT_DEFINES_SVH
`define ERROR_LOG_TABLE_DEDUP_EVICT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ELOG_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("elog assertion failed");
`define ELOG_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("elog assertion failed");
`else
`define ELOG_ASSERT(label, clk, rst_n, prop)
`define ELOG_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/core/elog_pkg.sv
// Types and constants shared by the error log table modules.
package elog_pkg;

	localparam logic CMD_LOG  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  slot_index;
		logic [15:0] err_code;
		logic [15:0] file_id;
		logic [7:0]  task_id;
		logic [15:0] src_line;
		logic [47:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  slot;
		logic        hit;
		logic        evicted;
		logic        occupied;
		logic [15:0] entry_code;
		logic [15:0] entry_file;
		logic [7:0]  entry_task;
		logic [15:0] entry_line;
		logic [47:0] entry_time;
		logic [15:0] entry_boot;
		logic [31:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic [15:0] code;
		logic [15:0] file;
		logic [7:0]  tsk;
		logic [15:0] line;
		logic [47:0] stamp;
		logic [15:0] boot;
		logic [31:0] count;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

	typedef struct packed {
		logic hit;
		logic evict;
	} scan_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_RD,
		ST_RDATA,
		ST_OUT
	} st_t;

endpackage

FILE: rtl/core/elog_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module elog_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/elog_scan.sv
// Table scan: first matching code, first empty slot and oldest slot.
`include "error_log_table_dedup_evict_defines.svh"
module elog_scan #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  elog_pkg::scan_ctl_t           ctl,
	input  logic [$clog2(ENTRIES)-1:0]    idx,
	input  elog_pkg::entry_t              ent,
	input  logic [15:0]                   code,
	output elog_pkg::scan_res_t           res,
	output logic [$clog2(ENTRIES)-1:0]    sel_idx,
	output logic [31:0]                   sel_count
);
	import elog_pkg::*;

	localparam int IW = $clog2(ENTRIES);

	logic          hit_q;
	logic          empty_q;
	logic          first_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] empty_idx_q;
	logic [IW-1:0] best_idx_q;
	logic [31:0]   hit_count_q;
	logic [63:0]   best_key_q;
	logic          occ;
	logic [63:0]   key;

	assign occ = (ent.stamp != 48'd0);
	assign key = {ent.boot, ent.stamp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
			first_q <= 1'b1;
		end else if (ctl.clear) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
			first_q <= 1'b1;
		end else if (ctl.sample) begin
			first_q <= 1'b0;
			if (!hit_q && occ && ent.code == code) begin
				hit_q <= 1'b1;
			end
			if (!empty_q && !occ) begin
				empty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sample) begin
			if (!hit_q && occ && ent.code == code) begin
				hit_idx_q   <= idx;
				hit_count_q <= ent.count;
			end
			if (!empty_q && !occ) begin
				empty_idx_q <= idx;
			end
			if (first_q || key < best_key_q) begin
				best_key_q <= key;
				best_idx_q <= idx;
			end
		end
	end

	always_comb begin
		res.hit   = hit_q;
		res.evict = !hit_q && !empty_q;
		sel_count = hit_q ? hit_count_q : 32'd0;
		if (hit_q) begin
			sel_idx = hit_idx_q;
		end else if (empty_q) begin
			sel_idx = empty_idx_q;
		end else begin
			sel_idx = best_idx_q;
		end
	end

	`ELOG_ASSERT_ALWAYS(a_ctl_excl, clk, !(ctl.clear && ctl.sample))
	`ELOG_ASSERT(a_hit_on_sample, clk, arst_n, $rose(hit_q) |-> $past(ctl.sample))
	`ELOG_ASSERT(a_empty_on_sample, clk, arst_n, $rose(empty_q) |-> $past(ctl.sample))

endmodule

FILE: rtl/core/error_log_table_dedup_evict.sv
// Error log table with code deduplication and oldest-entry eviction (top level).
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------
//  cfg      | in        | cfg_we             | cfg_wdata (current boot)
//  in       | in        | in_valid/in_stall  | in_item  (log or read)
//  out      | out       | out_valid/out_stall| out_item (slot contents)
//
// A log item scans the table with one table RAM read per cycle, then passes
// a drain state and a write-back state before the result load. A read item
// reads its slot and loads the result. One item is in work at a time; a waiting
// result in the output register does not block acceptance of the next item.
// Reset clears per-slot valid flops at once; unwritten slots read as zero.
`include "error_log_table_dedup_evict_defines.svh"
module error_log_table_dedup_evict #(
	parameter int ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  elog_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output elog_pkg::out_item_t out_item
);
	import elog_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int EW = $bits(entry_t);

	st_t           state_q;
	st_t           state_d;
	logic [IW-1:0] cnt_q;
	in_item_t      item_q;
	logic [15:0]   boot_q;
	logic [ENTRIES-1:0] valid_q;
	logic          smp_s1;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;
	out_item_t     res_q;
	out_item_t     out_q;
	logic          out_valid_q;

	logic          accept;
	logic          out_load;
	logic          ram_we;
	logic [IW-1:0] raddr;
	logic [EW-1:0] ram_rdata;
	entry_t        rd_ent;
	entry_t        wentry;
	logic          rd_oor;
	scan_ctl_t     scan_ctl;
	scan_res_t     scan_res;
	logic [IW-1:0] sel_idx;
	logic [31:0]   sel_count;

	function automatic out_item_t make_out(logic [3:0] slot, logic hit, logic evicted,
			entry_t e);
		out_item_t o;
		o.slot        = slot;
		o.hit         = hit;
		o.evicted     = evicted;
		o.occupied    = (e.stamp != 48'd0);
		o.entry_code  = e.code;
		o.entry_file  = e.file;
		o.entry_task  = e.tsk;
		o.entry_line  = e.line;
		o.entry_time  = e.stamp;
		o.entry_boot  = e.boot;
		o.entry_count = e.count;
		return o;
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign raddr  = (state_q == ST_RD) ? IW'(item_q.slot_index) : cnt_q;
	assign rd_ent = vld_s1 ? entry_t'(ram_rdata) : '0;
	assign rd_oor = (int'(item_q.slot_index) >= ENTRIES);

	assign scan_ctl.clear  = accept;
	assign scan_ctl.sample = smp_s1;

	always_comb begin
		wentry.code  = item_q.err_code;
		wentry.file  = item_q.file_id;
		wentry.tsk   = item_q.task_id;
		wentry.line  = item_q.src_line;
		wentry.stamp = item_q.timestamp;
		wentry.boot  = boot_q;
		wentry.count = (sel_count == COUNT_MAX) ? sel_count : sel_count + 32'd1;
	end

	elog_ram #(
		.WIDTH(EW),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(sel_idx),
		.wdata(wentry),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	elog_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (idx_s1),
		.ent      (rd_ent),
		.code     (item_q.err_code),
		.res      (scan_res),
		.sel_idx  (sel_idx),
		.sel_count(sel_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_item.cmd == CMD_READ) ? ST_RD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == IW'(ENTRIES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_WRITE;
			ST_WRITE: begin
				ram_we  = 1'b1;
				state_d = ST_OUT;
			end
			ST_RD:    state_d = ST_RDATA;
			ST_RDATA: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			smp_s1      <= 1'b0;
			boot_q      <= 16'd0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + IW'(1);
			end
			smp_s1 <= (state_q == ST_SCAN);
			if (cfg_we) begin
				boot_q <= cfg_wdata;
			end
			if (ram_we) begin
				valid_q[sel_idx] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		vld_s1 <= (int'(raddr) < ENTRIES) && valid_q[raddr];
		if (accept) begin
			item_q <= in_item;
		end
		if (state_q == ST_WRITE) begin
			res_q <= make_out(4'(sel_idx), scan_res.hit, scan_res.evict, wentry);
		end else if (state_q == ST_RDATA) begin
			res_q <= make_out(item_q.slot_index, 1'b0, 1'b0, rd_oor ? '0 : rd_ent);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	`ELOG_ASSERT(a_we_then_out, clk, arst_n, ram_we |=> (state_q == ST_OUT))
	`ELOG_ASSERT(a_hold_result, clk, arst_n, (state_q == ST_OUT && out_valid_q && out_stall) |=> (state_q == ST_OUT && $stable(out_q)))
	`ELOG_ASSERT(a_hit_excl, clk, arst_n, out_valid |-> !(out_item.hit && out_item.evicted))

endmodule

FILE: test/error_log_table_dedup_evict_test.sv
// Testbench for the error log table: directed rows, random traffic, shadow-table checking.
`timescale 1ns / 1ps

module error_log_table_dedup_evict_test;
	import elog_pkg::*;

	localparam int SLOTS = 16;
	localparam int DRAIN_CYCLES = 2 * (SLOTS + 4);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int CODE_POOL = 24;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	entry_t      shadow_table [SLOTS];
	logic [15:0] shadow_boot = '0;
	out_item_t   expected_slot_reports [$];
	stim_row_t   directed_rows [$];
	logic [15:0] code_pool [CODE_POOL];
	logic [47:0] log_clock = 48'd1;
	int          err_count = 0;
	int          reports_seen = 0;
	int          cycles = 0;
	int          burst_left = 0;

	error_log_table_dedup_evict #(
		.ENTRIES(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic out_item_t slot_report(int idx);
		out_item_t r;
		r = '0;
		r.slot = idx[3:0];
		r.occupied = shadow_table[idx].stamp != '0;
		r.entry_code = shadow_table[idx].code;
		r.entry_file = shadow_table[idx].file;
		r.entry_task = shadow_table[idx].tsk;
		r.entry_line = shadow_table[idx].line;
		r.entry_time = shadow_table[idx].stamp;
		r.entry_boot = shadow_table[idx].boot;
		r.entry_count = shadow_table[idx].count;
		return r;
	endfunction

	// applies one item to the shadow table and returns the slot report it causes
	function automatic out_item_t apply_to_shadow_log(in_item_t it);
		out_item_t r;
		int idx;
		bit found;
		bit evict;
		if (it.cmd == CMD_READ) begin
			return slot_report(int'(it.slot_index));
		end
		found = 1'b0;
		evict = 1'b0;
		idx = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && shadow_table[i].stamp != '0 && shadow_table[i].code == it.err_code) begin
				idx = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (idx < 0 && shadow_table[i].stamp == '0)
					idx = i;
			end
			if (idx < 0) begin
				idx = 0;
				evict = 1'b1;
				for (int i = 1; i < SLOTS; i++) begin
					if (shadow_table[i].boot < shadow_table[idx].boot ||
					    (shadow_table[i].boot == shadow_table[idx].boot &&
					     shadow_table[i].stamp < shadow_table[idx].stamp))
						idx = i;
				end
			end
			shadow_table[idx].count = '0;
		end
		shadow_table[idx].code = it.err_code;
		shadow_table[idx].file = it.file_id;
		shadow_table[idx].tsk = it.task_id;
		shadow_table[idx].line = it.src_line;
		shadow_table[idx].stamp = it.timestamp;
		shadow_table[idx].boot = shadow_boot;
		if (shadow_table[idx].count != COUNT_MAX)
			shadow_table[idx].count = shadow_table[idx].count + 32'd1;
		r = slot_report(idx);
		r.hit = found;
		r.evicted = evict;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_report(out_item_t got, out_item_t want);
		if (got.slot !== want.slot)
			report_mismatch($sformatf("slot got %h want %h", got.slot, want.slot));
		if (got.hit !== want.hit)
			report_mismatch($sformatf("hit got %b want %b (slot %0d)", got.hit, want.hit, want.slot));
		if (got.evicted !== want.evicted)
			report_mismatch($sformatf("evicted got %b want %b (slot %0d)", got.evicted,
				want.evicted, want.slot));
		if (got.occupied !== want.occupied)
			report_mismatch($sformatf("occupied got %b want %b (slot %0d)", got.occupied,
				want.occupied, want.slot));
		if (got.entry_code !== want.entry_code)
			report_mismatch($sformatf("entry_code got %h want %h (slot %0d)", got.entry_code,
				want.entry_code, want.slot));
		if (got.entry_file !== want.entry_file)
			report_mismatch($sformatf("entry_file got %h want %h (slot %0d)", got.entry_file,
				want.entry_file, want.slot));
		if (got.entry_task !== want.entry_task)
			report_mismatch($sformatf("entry_task got %h want %h (slot %0d)", got.entry_task,
				want.entry_task, want.slot));
		if (got.entry_line !== want.entry_line)
			report_mismatch($sformatf("entry_line got %h want %h (slot %0d)", got.entry_line,
				want.entry_line, want.slot));
		if (got.entry_time !== want.entry_time)
			report_mismatch($sformatf("entry_time got %h want %h (slot %0d)", got.entry_time,
				want.entry_time, want.slot));
		if (got.entry_boot !== want.entry_boot)
			report_mismatch($sformatf("entry_boot got %h want %h (slot %0d)", got.entry_boot,
				want.entry_boot, want.slot));
		if (got.entry_count !== want.entry_count)
			report_mismatch($sformatf("entry_count got %h want %h (slot %0d)", got.entry_count,
				want.entry_count, want.slot));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			reports_seen++;
			if (expected_slot_reports.size() == 0)
				report_mismatch($sformatf("unexpected item, slot %0d", out_item.slot));
			else
				check_report(out_item, expected_slot_reports.pop_front());
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("error_log_table_dedup_evict_test: done, errors");
			$finish;
		end
	end

	// output side: random stalls, plus one long hold to back the block up
	initial begin : receiver
		int run;
		int r;
		bit held;
		run = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && reports_seen >= HOLD_AT) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (run > 0) begin
				run--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 35) begin
					out_stall <= 1'b0;
					run = $urandom_range(0, 8);
				end else if (r < 45) begin
					out_stall <= 1'b0;
					run = $urandom_range(50, 150);
				end else if (r < 93) begin
					out_stall <= 1'b1;
					run = $urandom_range(0, 3);
				end else begin
					out_stall <= 1'b1;
					run = $urandom_range(10, 50);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 10) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 75)
			return $urandom_range(0, 2);
		if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		int gap;
		out_item_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = apply_to_shadow_log(it);
		expected_slot_reports.push_back(typed ? want : predicted);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_slot_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_boot(logic [15:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_boot = value;
	endtask

	function automatic in_item_t log_item(logic [15:0] code, logic [15:0] file, logic [7:0] tsk,
			logic [15:0] line, logic [47:0] stamp);
		in_item_t it;
		it = '0;
		it.cmd = CMD_LOG;
		it.err_code = code;
		it.file_id = file;
		it.task_id = tsk;
		it.src_line = line;
		it.timestamp = stamp;
		return it;
	endfunction

	function automatic in_item_t read_item(logic [3:0] idx);
		in_item_t it;
		it = '0;
		it.cmd = CMD_READ;
		it.slot_index = idx;
		return it;
	endfunction

	task automatic add_row(in_item_t it, bit typed, out_item_t want);
		stim_row_t row;
		row.item = it;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// directed rows run with the boot register at its maximum
	task automatic build_directed();
		in_item_t it;
		add_row(read_item(4'd0), 1'b1, '{slot: 4'd0, default: '0});
		add_row(read_item(4'd15), 1'b1, '{slot: 4'd15, default: '0});
		it = log_item(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		it.slot_index = 4'hF;
		add_row(it, 1'b1, '{slot: 4'd0, hit: 1'b0, evicted: 1'b0, occupied: 1'b1,
			entry_code: 16'hFFFF, entry_file: 16'hFFFF, entry_task: 8'hFF,
			entry_line: 16'hFFFF, entry_time: 48'hFFFF_FFFF_FFFF, entry_boot: 16'hFFFF,
			entry_count: 32'd2 - 32'd1});
		add_row(log_item(16'hFFFF, 16'h0, 8'h0, 16'h0, 48'd1), 1'b1, '{slot: 4'd0, hit: 1'b1,
			evicted: 1'b0, occupied: 1'b1, entry_code: 16'hFFFF, entry_file: 16'h0,
			entry_task: 8'h0, entry_line: 16'h0, entry_time: 48'd1, entry_boot: 16'hFFFF,
			entry_count: 32'd2});
		// zero timestamp: written but still empty
		add_row(log_item(16'h0000, 16'h1234, 8'h00, 16'h0000, 48'd0), 1'b1, '{slot: 4'd1,
			hit: 1'b0, evicted: 1'b0, occupied: 1'b0, entry_code: 16'h0, entry_file: 16'h1234,
			entry_task: 8'h0, entry_line: 16'h0, entry_time: 48'd0, entry_boot: 16'hFFFF,
			entry_count: 32'd1});
		add_row(log_item(16'h0000, 16'hA5A5, 8'h5A, 16'h0001, 48'd5), 1'b0, '0);
		for (int k = 2; k < SLOTS; k++)
			add_row(log_item(16'(k), 16'(k * 3), 8'(k), 16'(k * 7), 48'(100 - k)), 1'b0, '0);
		// table full: new codes evict the oldest
		add_row(log_item(16'h8000, 16'h0F0F, 8'h81, 16'h7FFF, 48'd200), 1'b0, '0);
		add_row(log_item(16'hFFFF, 16'hF0F0, 8'h7E, 16'h8000, 48'd201), 1'b0, '0);
		add_row(read_item(4'd0), 1'b0, '0);
		add_row(read_item(4'd15), 1'b0, '0);
		// read item carrying junk in the log fields
		it = log_item(16'hDEAD, 16'hBEEF, 8'hC3, 16'h3C3C, 48'h8000_0000_0001);
		it.cmd = CMD_READ;
		it.slot_index = 4'd7;
		add_row(it, 1'b0, '0);
	endtask

	function automatic in_item_t random_item();
		in_item_t it;
		int r;
		it.cmd = ($urandom_range(0, 99) < 25) ? CMD_READ : CMD_LOG;
		it.slot_index = 4'($urandom);
		it.file_id = 16'($urandom);
		it.task_id = 8'($urandom);
		it.src_line = 16'($urandom);
		if ($urandom_range(0, 99) < 85)
			it.err_code = code_pool[$urandom_range(0, CODE_POOL - 1)];
		else
			it.err_code = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 70) begin
			log_clock = log_clock + 48'($urandom_range(1, 1000));
			it.timestamp = log_clock;
		end else if (r < 80) begin
			it.timestamp = 48'($urandom_range(1, 3));
		end else if (r < 85) begin
			it.timestamp = '0;
		end else if (r < 90) begin
			it.timestamp = 48'hFFFF_FFFF_FFFF;
		end else begin
			it.timestamp = {16'($urandom), 32'($urandom)};
		end
		return it;
	endfunction

	initial begin : stimulus
		logic [15:0] phase_boot [RANDOM_PHASES];
		for (int i = 0; i < SLOTS; i++)
			shadow_table[i] = '0;
		code_pool[0] = 16'h0000;
		code_pool[1] = 16'hFFFF;
		for (int i = 2; i < CODE_POOL; i++)
			code_pool[i] = 16'($urandom);
		phase_boot[0] = 16'h0000;
		phase_boot[1] = 16'($urandom_range(1, 16'hFFFE));
		phase_boot[2] = 16'hFFFF;
		phase_boot[3] = 16'($urandom_range(1, 16'h7FFF));
		phase_boot[4] = 16'h0000;
		build_directed();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_boot(16'hFFFF);
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_boot(phase_boot[p]);
			repeat (ITEMS_PER_PHASE)
				send_item(random_item(), 1'b0, '0);
		end

		wait_idle();
		if (err_count == 0)
			$display("error_log_table_dedup_evict_test: done, clean");
		else
			$display("error_log_table_dedup_evict_test: done, errors");
		$finish;
	end

endmodule
